/* rtl/angle_kalman_filter_step_macros.svh */
// assertion helpers for the angle kalman filter step
`ifndef ANGLE_KALMAN_FILTER_STEP_MACROS_SVH
`define ANGLE_KALMAN_FILTER_STEP_MACROS_SVH

// same-cycle implication
`define AKF_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define AKF_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/akf_pkg.sv */
`default_nettype none
package akf_pkg;

  localparam int WORD_W = 32;
  localparam int DT_W   = 16;
  localparam int OPND_W = 36;
  localparam int PROD_W = 2 * OPND_W;
  localparam int EXT_W  = PROD_W + 2;
  localparam int NUM_W  = 64;
  localparam int FRAC_DT  = 16;
  localparam int FRAC_COV = 30;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_QA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QB = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_R  = 2'd2;

  localparam logic [WORD_W-1:0] QA_RESET = 32'd1073742;
  localparam logic [WORD_W-1:0] QB_RESET = 32'd3221225;
  localparam logic [WORD_W-1:0] R_RESET  = 32'd32212255;

  localparam logic signed [EXT_W-1:0] WMAX = 74'sd2147483647;
  localparam logic signed [EXT_W-1:0] WMIN = -74'sd2147483648;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_TAKE, ST_DIV, ST_DIV_WAIT, ST_OUT
  } akf_state_e;

  typedef enum logic [3:0] {
    OP_ANG, OP_T, OP_P00, OP_P11, OP_K0Y, OP_K1Y, OP_C10, OP_C11, OP_C00, OP_C01
  } akf_op_e;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0]  num;
    logic signed [OPND_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic signed [NUM_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [EXT_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > WMAX) r = WMAX[WORD_W-1:0];
    else if (v < WMIN) r = WMIN[WORD_W-1:0];
    else r = v[WORD_W-1:0];
    return r;
  endfunction

  function automatic akf_op_e next_op(input akf_op_e op);
    akf_op_e n;
    case (op)
      OP_ANG:  n = OP_T;
      OP_T:    n = OP_P00;
      OP_P00:  n = OP_P11;
      OP_P11:  n = OP_K0Y;
      OP_K0Y:  n = OP_K1Y;
      OP_K1Y:  n = OP_C10;
      OP_C10:  n = OP_C11;
      OP_C11:  n = OP_C00;
      OP_C00:  n = OP_C01;
      default: n = OP_ANG;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/akf_mul.sv */
`default_nettype none
module akf_mul (
  input  wire                               clk_i,
  input  wire                               en_i,
  input  wire  signed [akf_pkg::OPND_W-1:0] a_i,
  input  wire  signed [akf_pkg::OPND_W-1:0] b_i,
  output logic signed [akf_pkg::PROD_W-1:0] p_o
);
  import akf_pkg::*;

  logic signed [PROD_W-1:0] p_q, p_d;

  // registered product
  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) p_q <= p_d;
  end

  assign p_o = p_q;
endmodule
`default_nettype wire

/* rtl/akf_div.sv */
`default_nettype none
module akf_div (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire  akf_pkg::div_req_t   req_i,
  output akf_pkg::div_rsp_t         rsp_o
);
  import akf_pkg::*;

  logic                  busy_q, done_q, neg_q;
  logic [5:0]            cnt_q;
  logic [OPND_W:0]       rem_q, rem_sh, rem_d;
  logic [OPND_W:0]       den_q;
  logic [NUM_W-1:0]      quo_q;
  logic                  qbit;
  logic [NUM_W-1:0]      num_mag;
  logic [OPND_W-1:0]     den_mag;

  assign num_mag = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : NUM_W'(req_i.num);
  assign den_mag = req_i.den[OPND_W-1] ? OPND_W'(-req_i.den) : OPND_W'(req_i.den);

  // restoring step, one quotient bit a cycle
  assign rem_sh = {rem_q[OPND_W-1:0], quo_q[NUM_W-1]};
  assign qbit   = (rem_sh >= den_q);
  assign rem_d  = qbit ? rem_sh - den_q : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[NUM_W-1] ^ req_i.den[OPND_W-1];
      quo_q <= num_mag;
      den_q <= {1'b0, den_mag};
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[NUM_W-2:0], qbit};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

  `include "angle_kalman_filter_step_macros.svh"

  `AKF_ASSERT_NXT(a_div_start_busy, req_i.start, busy_q, "divider did not start")
  `AKF_ASSERT_IMP(a_div_done_idle, done_q, !busy_q, "divider done while busy")
  `AKF_ASSERT_IMP(a_div_no_restart, busy_q, !req_i.start, "divider restarted while busy")
endmodule
`default_nettype wire

/* rtl/angle_kalman_filter_step.sv */
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid_i/tready_o       measured_angle, measured_rate, time_step
// m_axis    out  m_axis_tvalid_o/tready_i       filtered_angle, unbiased_rate
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// each item runs ten products in turn on the shared multiplier, with two gain
// divisions after the fourth, then loads the output register and returns to idle
// zero innovation variance skips both divisions
// tready is high only while the sequencer is idle; a stalled receiver holds the
// finished item in the output register, so the next item may still enter
// reset clears the estimates and the covariance and reloads the noise registers
`default_nettype none
module angle_kalman_filter_step (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // measured_angle [31:0], measured_rate [63:32], time_step [79:64]
  input  wire  [79:0]                  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  wire                          m_axis_tready_i,
  // filtered_angle [31:0], unbiased_rate [63:32]
  output logic [63:0]                  m_axis_tdata_o,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [akf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [akf_pkg::WORD_W-1:0]   cfg_data_i
);
  import akf_pkg::*;

  akf_state_e state_q, state_d;
  akf_op_e    op_q, op_d;
  logic       sel_q, sel_d;

  logic [WORD_W-1:0] qa_q, qb_q, r_q;

  // filter state
  logic signed [WORD_W-1:0] angle_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  // per-item working registers
  logic signed [WORD_W-1:0] meas_q, rate_q, k0_q, k1_q;
  logic [DT_W-1:0]          dt_q;
  logic signed [33:0]       t_q, y_q;

  logic                     out_valid_q;
  logic [63:0]              out_data_q;

  logic                     in_acc, out_load, s_zero;
  logic signed [OPND_W-1:0] mul_a, mul_b, s_val, inner;
  logic signed [PROD_W-1:0] prod;
  logic signed [EXT_W-1:0]  sh16, sh30;
  logic signed [WORD_W-1:0] ang_pred;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_load        = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready_i);

  // innovation variance, zero means no correction
  assign s_val  = OPND_W'(p00_q) + $signed({4'd0, r_q});
  assign s_zero = (s_val == '0);

  assign inner = OPND_W'(t_q) - OPND_W'(p01_q) - OPND_W'(p10_q) + $signed({4'd0, qa_q});

  // next state
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_ISSUE;
          op_d    = OP_ANG;
        end
      end
      ST_ISSUE: state_d = ST_TAKE;
      ST_TAKE: begin
        if (op_q == OP_P11) begin
          state_d = ST_DIV;
          sel_d   = 1'b0;
        end else if (op_q == OP_C01) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_ISSUE;
          op_d    = next_op(op_q);
        end
      end
      ST_DIV: begin
        if (s_zero) begin
          state_d = ST_ISSUE;
          op_d    = OP_K0Y;
        end else begin
          state_d = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (!sel_q) begin
            state_d = ST_DIV;
            sel_d   = 1'b1;
          end else begin
            state_d = ST_ISSUE;
            op_d    = OP_K0Y;
          end
        end
      end
      ST_OUT: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // unit operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      OP_ANG: begin mul_a = $signed({20'd0, dt_q}); mul_b = OPND_W'(rate_q); end
      OP_T:   begin mul_a = $signed({20'd0, dt_q}); mul_b = OPND_W'(p11_q); end
      OP_P00: begin mul_a = $signed({20'd0, dt_q}); mul_b = inner; end
      OP_P11: begin mul_a = $signed({20'd0, dt_q}); mul_b = $signed({4'd0, qb_q}); end
      OP_K0Y: begin mul_a = OPND_W'(k0_q); mul_b = OPND_W'(y_q); end
      OP_K1Y: begin mul_a = OPND_W'(k1_q); mul_b = OPND_W'(y_q); end
      OP_C10: begin mul_a = OPND_W'(k1_q); mul_b = OPND_W'(p00_q); end
      OP_C11: begin mul_a = OPND_W'(k1_q); mul_b = OPND_W'(p01_q); end
      OP_C00: begin mul_a = OPND_W'(k0_q); mul_b = OPND_W'(p00_q); end
      OP_C01: begin mul_a = OPND_W'(k0_q); mul_b = OPND_W'(p01_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    div_req.start = (state_q == ST_DIV) && !s_zero;
    div_req.num   = (sel_q ? NUM_W'(p10_q) : NUM_W'(p00_q)) <<< FRAC_COV;
    div_req.den   = s_val;
  end

  akf_mul u_mul (
    .clk_i (clk_i),
    .en_i  (state_q == ST_ISSUE),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  akf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // floor-scaled products
  assign sh16     = EXT_W'(prod >>> FRAC_DT);
  assign sh30     = EXT_W'(prod >>> FRAC_COV);
  assign ang_pred = sat_word(EXT_W'(angle_q) + sh16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ANG;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      qa_q        <= QA_RESET;
      qb_q        <= QB_RESET;
      r_q         <= R_RESET;
      angle_q     <= '0;
      bias_q      <= '0;
      p00_q       <= '0;
      p01_q       <= '0;
      p10_q       <= '0;
      p11_q       <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      sel_q   <= sel_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_QA:  qa_q <= cfg_data_i;
          REG_QB:  qb_q <= cfg_data_i;
          REG_R:   r_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_TAKE) begin
        case (op_q)
          OP_ANG: angle_q <= ang_pred;
          OP_P00: begin
            p00_q <= sat_word(EXT_W'(p00_q) + sh16);
            p01_q <= sat_word(EXT_W'(p01_q) - EXT_W'(t_q));
            p10_q <= sat_word(EXT_W'(p10_q) - EXT_W'(t_q));
          end
          OP_P11: p11_q   <= sat_word(EXT_W'(p11_q) + sh16);
          OP_K0Y: angle_q <= sat_word(EXT_W'(angle_q) + sh30);
          OP_K1Y: bias_q  <= sat_word(EXT_W'(bias_q) + sh30);
          OP_C10: p10_q   <= sat_word(EXT_W'(p10_q) - sh30);
          OP_C11: p11_q   <= sat_word(EXT_W'(p11_q) - sh30);
          OP_C00: p00_q   <= sat_word(EXT_W'(p00_q) - sh30);
          OP_C01: p01_q   <= sat_word(EXT_W'(p01_q) - sh30);
          default: ;
        endcase
      end
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      meas_q <= $signed(s_axis_tdata_i[31:0]);
      dt_q   <= s_axis_tdata_i[79:64];
      rate_q <= sat_word(EXT_W'($signed(s_axis_tdata_i[63:32])) - EXT_W'(bias_q));
    end
    if (state_q == ST_TAKE && op_q == OP_ANG) y_q <= 34'(meas_q) - 34'(ang_pred);
    if (state_q == ST_TAKE && op_q == OP_T)   t_q <= 34'(prod >>> FRAC_DT);
    if (state_q == ST_DIV && s_zero) begin
      k0_q <= '0;
      k1_q <= '0;
    end
    if (state_q == ST_DIV_WAIT && div_rsp.done) begin
      if (sel_q) k1_q <= sat_word(EXT_W'(div_rsp.quo));
      else       k0_q <= sat_word(EXT_W'(div_rsp.quo));
    end
    if (out_load) out_data_q <= {rate_q, angle_q};
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  `include "angle_kalman_filter_step_macros.svh"

  `AKF_ASSERT_NXT(a_acc_leaves_idle, in_acc, state_q == ST_ISSUE, "item accepted but no start")
  `AKF_ASSERT_IMP(a_div_only_waiting, div_rsp.busy, state_q == ST_DIV_WAIT, "divider busy off wait")
  `AKF_ASSERT_NXT(a_load_from_out, out_load, out_valid_q && state_q == ST_IDLE, "result not loaded")
endmodule
`default_nettype wire
